// File: design/ipv4lpm_pkg.sv
// ipv4lpm_pkg: shared types, codes and helpers of the ipv4 lpm forwarder
// no dependencies
`default_nettype none

package ipv4lpm_pkg;

  localparam int unsigned AddrW      = 32;
  localparam int unsigned LenW       = 6;
  localparam int unsigned SumW       = 21;
  localparam int unsigned WordIdxW   = 4;
  localparam int unsigned MaxWords   = 15;
  localparam int unsigned TtlWord    = 2;
  localparam int unsigned DestWord   = 4;
  localparam int unsigned MaxLen     = 32;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_HDR   = 2'd2
  } ipv4lpm_cmd_e;

  typedef enum logic [2:0] {
    OUT_LOCAL   = 3'd0,
    OUT_TTL_EXP = 3'd1,
    OUT_NOROUTE = 3'd2,
    OUT_FWD     = 3'd3,
    OUT_ADDED   = 3'd4,
    OUT_FULL    = 3'd5,
    OUT_CLEARED = 3'd6
  } ipv4lpm_outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } ipv4lpm_state_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [AddrW-1:0]  route_prefix;
    logic [LenW-1:0]   prefix_length;
    logic [AddrW-1:0]  next_hop;
    logic [AddrW-1:0]  header_word;
    logic              last_word;
  } ipv4lpm_in_t;

  typedef struct packed {
    ipv4lpm_outcome_e  outcome;
    logic [AddrW-1:0]  forward_address;
    logic [7:0]        new_ttl;
    logic [15:0]       new_checksum;
  } ipv4lpm_out_t;

  typedef struct packed {
    logic [AddrW-1:0]  prefix;
    logic [LenW-1:0]   len;
    logic [AddrW-1:0]  hop;
  } ipv4lpm_entry_t;

  // controller to datapath
  typedef struct packed {
    logic              accept;
    logic              imm_load;
    ipv4lpm_outcome_e  imm_outcome;
    logic              scan_start;
    logic              scan_run;
    logic              fwd_load;
  } ipv4lpm_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
    logic local_hit;
    logic ttl_zero;
    logic table_empty;
    logic table_full;
    logic scan_end;
  } ipv4lpm_stat_t;

  function automatic logic [AddrW-1:0] prefix_mask(input logic [LenW-1:0] len);
    logic [AddrW-1:0] m;
    m = '0;
    if (len != '0) begin
      m = {AddrW{1'b1}} << (LenW'(MaxLen) - len);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: design/ipv4lpm_ctrl.sv
// ipv4lpm_ctrl: sequencing state machine of the ipv4 lpm forwarder
// depends on ipv4lpm_pkg
`default_nettype none

module ipv4lpm_ctrl import ipv4lpm_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    in_cmd_i,
  input  wire logic          in_last_i,
  output logic               in_ready_o,
  input  wire ipv4lpm_stat_t stat_i,
  output ipv4lpm_ctrl_t      ctrl_o
);

  ipv4lpm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d            = state_q;
    in_ready_o         = 1'b0;
    ctrl_o             = '0;
    ctrl_o.imm_outcome = OUT_LOCAL;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = !stat_i.out_busy;
        ctrl_o.accept = in_valid_i && in_ready_o;
        if (ctrl_o.accept) begin
          priority if (in_cmd_i == CMD_CLEAR) begin
            ctrl_o.imm_load    = 1'b1;
            ctrl_o.imm_outcome = OUT_CLEARED;
          end else if (in_cmd_i == CMD_ADD) begin
            ctrl_o.imm_load    = 1'b1;
            ctrl_o.imm_outcome = stat_i.table_full ? OUT_FULL : OUT_ADDED;
          end else if (in_cmd_i == CMD_HDR && in_last_i) begin
            priority if (stat_i.local_hit) begin
              ctrl_o.imm_load    = 1'b1;
              ctrl_o.imm_outcome = OUT_LOCAL;
            end else if (stat_i.ttl_zero) begin
              ctrl_o.imm_load    = 1'b1;
              ctrl_o.imm_outcome = OUT_TTL_EXP;
            end else if (stat_i.table_empty) begin
              ctrl_o.imm_load    = 1'b1;
              ctrl_o.imm_outcome = OUT_NOROUTE;
            end else begin
              ctrl_o.scan_start = 1'b1;
              state_d           = ST_SCAN;
            end
          end else begin
            ctrl_o.imm_load = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        ctrl_o.scan_run = 1'b1;
        if (stat_i.scan_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat_i.out_busy) begin
          ctrl_o.fwd_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/ipv4lpm_dp.sv
// ipv4lpm_dp: route memory, header accumulation, prefix scan and result register
// depends on ipv4lpm_pkg
`default_nettype none

module ipv4lpm_dp import ipv4lpm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ipv4lpm_in_t   in_data_i,
  input  wire logic          cfg_valid_i,
  input  wire logic [31:0]   cfg_data_i,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output ipv4lpm_out_t       out_data_o,
  input  wire ipv4lpm_ctrl_t ctrl_i,
  output ipv4lpm_stat_t      stat_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  // configuration
  logic [AddrW-1:0] local_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
    end else if (cfg_valid_i) begin
      local_addr_q <= cfg_data_i;
    end
  end

  // header accumulation
  logic [WordIdxW-1:0] word_idx_q, word_idx_d;
  logic [SumW-1:0]     run_sum_q, run_sum_d;
  logic [7:0]          held_ttl_q, held_ttl_d;
  logic [AddrW-1:0]    held_dest_q, held_dest_d;
  logic                hdr_xfer;

  assign hdr_xfer = ctrl_i.accept && (in_data_i.cmd == CMD_HDR);

  always_comb begin
    word_idx_d  = word_idx_q;
    run_sum_d   = run_sum_q;
    held_ttl_d  = held_ttl_q;
    held_dest_d = held_dest_q;
    if (word_idx_q < WordIdxW'(MaxWords)) begin
      run_sum_d = run_sum_q + SumW'(in_data_i.header_word[31:16]);
      if (word_idx_q != WordIdxW'(TtlWord)) begin
        run_sum_d = run_sum_d + SumW'(in_data_i.header_word[15:0]);
      end else begin
        held_ttl_d = in_data_i.header_word[31:24];
      end
      if (word_idx_q == WordIdxW'(DestWord)) begin
        held_dest_d = in_data_i.header_word;
      end
      word_idx_d = word_idx_q + WordIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_idx_q  <= '0;
      run_sum_q   <= '0;
      held_ttl_q  <= '0;
      held_dest_q <= '0;
    end else if (hdr_xfer) begin
      if (in_data_i.last_word) begin
        word_idx_q  <= '0;
        run_sum_q   <= '0;
        held_ttl_q  <= '0;
        held_dest_q <= '0;
      end else begin
        word_idx_q  <= word_idx_d;
        run_sum_q   <= run_sum_d;
        held_ttl_q  <= held_ttl_d;
        held_dest_q <= held_dest_d;
      end
    end
  end

  // route table
  ipv4lpm_entry_t mem_q [TABLE_DEPTH];
  ipv4lpm_entry_t new_entry;
  ipv4lpm_entry_t rdata_q;
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] rd_idx_q;
  logic [LenW-1:0] add_len;
  logic            table_full;

  assign table_full = (count_q == CntW'(TABLE_DEPTH));
  assign add_len    = (in_data_i.prefix_length > LenW'(MaxLen)) ? LenW'(MaxLen)
                                                                : in_data_i.prefix_length;
  assign new_entry  = '{prefix: in_data_i.route_prefix & prefix_mask(add_len),
                        len:    add_len,
                        hop:    in_data_i.next_hop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.accept) begin
      if (in_data_i.cmd == CMD_CLEAR) begin
        count_q <= '0;
      end else if (in_data_i.cmd == CMD_ADD && !table_full) begin
        count_q <= count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept && in_data_i.cmd == CMD_ADD && !table_full) begin
      mem_q[count_q[IdxW-1:0]] <= new_entry;
    end
    rdata_q <= mem_q[rd_idx_q];
  end

  // scan
  logic [AddrW-1:0] s_dest_q;
  logic [7:0]       s_ttl_q;
  logic [SumW-1:0]  s_sum_q;
  logic [SumW-1:0]  sum_dec;
  logic [16:0]      fold1_q;
  logic [16:0]      fold2;
  logic             cmp_valid_q;
  logic [LenW-1:0]  best_len_q;
  logic [AddrW-1:0] best_hop_q;
  logic             hit;

  assign hit = cmp_valid_q && (rdata_q.len > best_len_q) &&
               ((s_dest_q & prefix_mask(rdata_q.len)) == rdata_q.prefix);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q    <= '0;
      cmp_valid_q <= 1'b0;
    end else begin
      cmp_valid_q <= ctrl_i.scan_run;
      if (ctrl_i.scan_start) begin
        rd_idx_q <= '0;
      end else if (ctrl_i.scan_run) begin
        rd_idx_q <= rd_idx_q + IdxW'(1);
      end
    end
  end

  // ttl nonzero on a scan, so its halfword drops by one without borrow
  assign sum_dec = s_sum_q - SumW'(16'h0100);
  assign fold2   = 17'(fold1_q[16]) + {1'b0, fold1_q[15:0]};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan_start) begin
      s_dest_q   <= held_dest_d;
      s_ttl_q    <= held_ttl_d;
      s_sum_q    <= run_sum_d;
      best_len_q <= '0;
    end else if (hit) begin
      best_len_q <= rdata_q.len;
      best_hop_q <= rdata_q.hop;
    end
    fold1_q <= 17'(sum_dec[SumW-1:16]) + 17'(sum_dec[15:0]);
  end

  // result register
  logic         out_valid_q;
  ipv4lpm_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.imm_load || ctrl_i.fwd_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.imm_load) begin
      out_q <= '{outcome: ctrl_i.imm_outcome, forward_address: '0,
                 new_ttl: '0, new_checksum: '0};
    end else if (ctrl_i.fwd_load) begin
      if (best_len_q == '0) begin
        out_q <= '{outcome: OUT_NOROUTE, forward_address: '0,
                   new_ttl: '0, new_checksum: '0};
      end else begin
        out_q <= '{outcome: OUT_FWD, forward_address: best_hop_q,
                   new_ttl: s_ttl_q - 8'd1, new_checksum: ~fold2[15:0]};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.out_busy    = out_valid_q && !out_ready_i;
  assign stat_o.local_hit   = (held_dest_d == local_addr_q);
  assign stat_o.ttl_zero    = (held_ttl_d == 8'd0);
  assign stat_o.table_empty = (count_q == '0);
  assign stat_o.table_full  = table_full;
  assign stat_o.scan_end    = (CntW'(rd_idx_q) == count_q - CntW'(1));

endmodule

`default_nettype wire

// File: design/ipv4_lpm_forwarder_top.sv
// ipv4_lpm_forwarder_top: ipv4 longest prefix match forwarder
// depends on ipv4lpm_pkg, ipv4lpm_ctrl, ipv4lpm_dp
//
// input channel (in_valid_i/in_ready_o, in_data_i) carries clear, add route and
// header word commands; output channel (out_valid_o/out_ready_i, out_data_o)
// carries one result per clear, add and final header word; cfg channel writes
// the local address and is always ready.
// clear, add, non-final header words and final words decided as local, ttl
// expired or no route with an empty table need no lookup, so they can follow
// back to back; a result shows the cycle after its transfer.
// a final word that needs a lookup walks the route memory one entry per cycle
// through its single read port, then passes the drain and finish states; no
// input is taken until its result is loaded.
// the result sits in an output register; no input is taken while it waits on
// a stalled receiver, so the input stalls along with the output.
// reset empties the table, drops any partial header and sets the local
// address to zero; the table memory itself is not cleared.
`default_nettype none

module ipv4_lpm_forwarder_top import ipv4lpm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire ipv4lpm_in_t  in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output ipv4lpm_out_t      out_data_o,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [31:0]  cfg_data_i
);

  ipv4lpm_ctrl_t ctrl;
  ipv4lpm_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ipv4lpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_last_i  (in_data_i.last_word),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ipv4lpm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire

// File: design/ipv4lpm_checker.sv
// ipv4lpm_checker: port level assertions for ipv4_lpm_forwarder_top, bound to it
// depends on ipv4lpm_pkg and ipv4_lpm_forwarder_top
`default_nettype none

module ipv4lpm_checker import ipv4lpm_pkg::*; (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         in_valid_i,
  input wire logic         in_ready_o,
  input wire ipv4lpm_in_t  in_data_i,
  input wire logic         out_valid_o,
  input wire logic         out_ready_i,
  input wire ipv4lpm_out_t out_data_o
);

  // result held until transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // only a forward carries address, ttl and checksum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outcome != OUT_FWD |->
      out_data_o.forward_address == '0 && out_data_o.new_ttl == '0 &&
      out_data_o.new_checksum == '0)
    else $error("non-forward result with payload");

  // clear answers in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.cmd == CMD_CLEAR |=>
      out_valid_o && out_data_o.outcome == OUT_CLEARED)
    else $error("clear not acknowledged");

  // add answers in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.cmd == CMD_ADD |=>
      out_valid_o && (out_data_o.outcome == OUT_ADDED || out_data_o.outcome == OUT_FULL))
    else $error("add not acknowledged");

  // a forwarded ttl came from a nonzero ttl
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outcome == OUT_FWD |-> out_data_o.new_ttl != 8'hff)
    else $error("forward with expired ttl");

endmodule

bind ipv4_lpm_forwarder_top ipv4lpm_checker u_ipv4lpm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
